FILE: hw/rtl/sss_pkg.sv
`timescale 1ns / 1ps

package sss_pkg;

  localparam int STORE_LEN_DEF = 16;
  localparam int DIGITS_DEF    = 4;

  localparam logic [8:0] INTERVAL_RESET = 9'd16;
  localparam logic [7:0] DOT_SEG        = 8'h80;

  typedef enum logic [3:0] {
    FUNC_TICK      = 4'd0,
    FUNC_PRINT     = 4'd1,
    FUNC_BEGIN     = 4'd2,
    FUNC_FILL      = 4'd3,
    FUNC_SET_DP    = 4'd4,
    FUNC_CLR_DP    = 4'd5,
    FUNC_SET_WIN   = 4'd6,
    FUNC_SHIFT_WIN = 4'd7,
    FUNC_SET_BASE  = 4'd8,
    FUNC_SCROLL_R  = 4'd9,
    FUNC_SCROLL_L  = 4'd10
  } func_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_RIGHT = 2'd1,
    MODE_LEFT  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ADDR_HOLD      = 3'd0,
    ADDR_CALC      = 3'd1,
    ADDR_NEXT      = 3'd2,
    ADDR_PREV_CELL = 3'd3,
    ADDR_CURSOR    = 3'd4
  } addr_t;

  typedef enum logic [2:0] {
    CALC_BASE_OFF   = 3'd0,
    CALC_OFF        = 3'd1,
    CALC_WIN_OFF    = 3'd2,
    CALC_BASE_DIG   = 3'd3,
    CALC_BASE_M2    = 3'd4,
    CALC_BASE_PDIG2 = 3'd5,
    CALC_BASE_NDIG2 = 3'd6
  } calc_t;

  typedef enum logic [1:0] {
    WD_GLYPH   = 2'd0,
    WD_ZERO    = 2'd1,
    WD_OR_DOT  = 2'd2,
    WD_CLR_DOT = 2'd3
  } wdata_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_FILL = 2'd1,
    CNT_TWO  = 2'd2,
    CNT_DEC  = 2'd3
  } cnt_t;

  typedef enum logic [2:0] {
    UPD_NONE        = 3'd0,
    UPD_CURSOR      = 3'd1,
    UPD_WIN         = 3'd2,
    UPD_BASE        = 3'd3,
    UPD_BASE_RIGHT  = 3'd4,
    UPD_BASE_LEFT   = 3'd5,
    UPD_PRINT_PLAIN = 3'd6,
    UPD_PRINT_DOT   = 3'd7
  } upd_t;

  typedef struct packed {
    logic   latch;
    logic   tick;
    logic   emit;
    logic   rd;
    logic   wr;
    addr_t  addr;
    calc_t  calc;
    wdata_t wd;
    cnt_t   cnt;
    upd_t   upd;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] func;
    logic       dot_merge;
    logic       cnt_zero;
    logic       out_free;
  } dp_stat_t;

  function automatic logic [7:0] glyph(input logic [7:0] ch);
    logic [7:0] seg;
    case (ch)
      8'h4F, 8'h30: seg = 8'h3F;
      8'h31:        seg = 8'h06;
      8'h32:        seg = 8'h5B;
      8'h33:        seg = 8'h4F;
      8'h34:        seg = 8'h66;
      8'h53, 8'h35: seg = 8'h6D;
      8'h36:        seg = 8'h7D;
      8'h37:        seg = 8'h07;
      8'h38:        seg = 8'h7F;
      8'h39:        seg = 8'h6F;
      8'h2E, 8'h2C: seg = 8'h80;
      8'h2D:        seg = 8'h40;
      8'h5F:        seg = 8'h08;
      8'h20:        seg = 8'h00;
      8'hB0:        seg = 8'h63;
      8'h43:        seg = 8'h39;
      8'h46:        seg = 8'h71;
      8'h4E:        seg = 8'h54;
      8'h44:        seg = 8'h5E;
      8'h50:        seg = 8'h73;
      8'h45:        seg = 8'h79;
      default:      seg = ch;
    endcase
    return seg;
  endfunction

endpackage

FILE: hw/rtl/sss_ctrl.sv
`timescale 1ns / 1ps

module sss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sss_pkg::dp_stat_t stat,
  output sss_pkg::dp_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DISPATCH = 9'b000000010,
    S_READ     = 9'b000000100,
    S_MODIFY   = 9'b000001000,
    S_WRITE    = 9'b000010000,
    S_APPLY    = 9'b000100000,
    S_FILL     = 9'b001000000,
    S_REBASE   = 9'b010000000,
    S_EMIT     = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '{latch: 1'b0, tick: 1'b0, emit: 1'b0, rd: 1'b0, wr: 1'b0,
                  addr: sss_pkg::ADDR_HOLD, calc: sss_pkg::CALC_BASE_OFF,
                  wd: sss_pkg::WD_GLYPH, cnt: sss_pkg::CNT_HOLD,
                  upd: sss_pkg::UPD_NONE};
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.func)
          sss_pkg::FUNC_TICK: begin
            cmd.tick  = 1'b1;
            state_nxt = S_EMIT;
          end
          sss_pkg::FUNC_PRINT: begin
            if (stat.dot_merge) begin
              cmd.addr  = sss_pkg::ADDR_PREV_CELL;
              state_nxt = S_READ;
            end else begin
              cmd.addr  = sss_pkg::ADDR_CURSOR;
              state_nxt = S_WRITE;
            end
          end
          sss_pkg::FUNC_BEGIN: begin
            cmd.addr  = sss_pkg::ADDR_CALC;
            cmd.calc  = sss_pkg::CALC_BASE_OFF;
            state_nxt = S_APPLY;
          end
          sss_pkg::FUNC_FILL: begin
            cmd.addr  = sss_pkg::ADDR_CALC;
            cmd.calc  = sss_pkg::CALC_BASE_OFF;
            cmd.cnt   = sss_pkg::CNT_FILL;
            state_nxt = S_FILL;
          end
          sss_pkg::FUNC_SET_DP, sss_pkg::FUNC_CLR_DP: begin
            cmd.addr  = sss_pkg::ADDR_CALC;
            cmd.calc  = sss_pkg::CALC_BASE_OFF;
            state_nxt = S_READ;
          end
          sss_pkg::FUNC_SET_WIN, sss_pkg::FUNC_SET_BASE: begin
            cmd.addr  = sss_pkg::ADDR_CALC;
            cmd.calc  = sss_pkg::CALC_OFF;
            state_nxt = S_APPLY;
          end
          sss_pkg::FUNC_SHIFT_WIN: begin
            cmd.addr  = sss_pkg::ADDR_CALC;
            cmd.calc  = sss_pkg::CALC_WIN_OFF;
            state_nxt = S_APPLY;
          end
          sss_pkg::FUNC_SCROLL_R: begin
            cmd.addr  = sss_pkg::ADDR_CALC;
            cmd.calc  = sss_pkg::CALC_BASE_DIG;
            cmd.cnt   = sss_pkg::CNT_TWO;
            state_nxt = S_FILL;
          end
          sss_pkg::FUNC_SCROLL_L: begin
            cmd.addr  = sss_pkg::ADDR_CALC;
            cmd.calc  = sss_pkg::CALC_BASE_M2;
            cmd.cnt   = sss_pkg::CNT_TWO;
            state_nxt = S_FILL;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_MODIFY;
      end
      S_MODIFY: begin
        cmd.wr    = 1'b1;
        cmd.wd    = (stat.func == sss_pkg::FUNC_CLR_DP) ? sss_pkg::WD_CLR_DOT
                                                        : sss_pkg::WD_OR_DOT;
        cmd.upd   = (stat.func == sss_pkg::FUNC_PRINT) ? sss_pkg::UPD_PRINT_DOT
                                                       : sss_pkg::UPD_NONE;
        state_nxt = S_IDLE;
      end
      S_WRITE: begin
        cmd.wr    = 1'b1;
        cmd.wd    = sss_pkg::WD_GLYPH;
        cmd.upd   = sss_pkg::UPD_PRINT_PLAIN;
        state_nxt = S_IDLE;
      end
      S_APPLY: begin
        unique case (stat.func)
          sss_pkg::FUNC_BEGIN:     cmd.upd = sss_pkg::UPD_CURSOR;
          sss_pkg::FUNC_SET_WIN,
          sss_pkg::FUNC_SHIFT_WIN: cmd.upd = sss_pkg::UPD_WIN;
          sss_pkg::FUNC_SET_BASE:  cmd.upd = sss_pkg::UPD_BASE;
          sss_pkg::FUNC_SCROLL_R:  cmd.upd = sss_pkg::UPD_BASE_RIGHT;
          sss_pkg::FUNC_SCROLL_L:  cmd.upd = sss_pkg::UPD_BASE_LEFT;
          default:                 cmd.upd = sss_pkg::UPD_NONE;
        endcase
        state_nxt = S_IDLE;
      end
      S_FILL: begin
        if (stat.cnt_zero) begin
          state_nxt = (stat.func == sss_pkg::FUNC_FILL) ? S_IDLE : S_REBASE;
        end else begin
          cmd.wr   = 1'b1;
          cmd.wd   = (stat.func == sss_pkg::FUNC_FILL) ? sss_pkg::WD_GLYPH
                                                       : sss_pkg::WD_ZERO;
          cmd.addr = sss_pkg::ADDR_NEXT;
          cmd.cnt  = sss_pkg::CNT_DEC;
        end
      end
      S_REBASE: begin
        cmd.addr  = sss_pkg::ADDR_CALC;
        cmd.calc  = (stat.func == sss_pkg::FUNC_SCROLL_R) ? sss_pkg::CALC_BASE_PDIG2
                                                          : sss_pkg::CALC_BASE_NDIG2;
        state_nxt = S_APPLY;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hw/rtl/sss_datapath.sv
`timescale 1ns / 1ps

module sss_datapath #(
  parameter int STORE_LEN = sss_pkg::STORE_LEN_DEF,
  parameter int DIGITS    = sss_pkg::DIGITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sss_pkg::dp_cmd_t  cmd,
  output sss_pkg::dp_stat_t stat,
  input  logic [3:0]        in_func,
  input  logic signed [7:0] in_offset,
  input  logic [7:0]        in_char_code,
  input  logic [4:0]        in_fill_length,
  input  logic              cfg_wr_en,
  input  logic [8:0]        cfg_wr_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_digit_index,
  output logic [7:0]        out_segment_bits,
  output logic              out_frame_start,
  output logic              out_scrolling
);

  localparam int PW   = $clog2(STORE_LEN);
  localparam int DW   = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int BIAS = STORE_LEN * ((128 + STORE_LEN - 1) / STORE_LEN);
  localparam logic [PW-1:0] LAST_CELL  = PW'(STORE_LEN - 1);
  localparam logic [DW-1:0] LAST_DIGIT = DW'(DIGITS - 1);
  localparam logic signed [9:0] B_DIG   = 10'(DIGITS);
  localparam logic signed [9:0] B_M2    = -10'sd2;
  localparam logic signed [9:0] B_PDIG2 = 10'(DIGITS + 2);
  localparam logic signed [9:0] B_NDIG2 = -10'(DIGITS + 2);

  function automatic logic [PW-1:0] cell_mod(input logic signed [9:0] s);
    logic [15:0] v;
    v = 16'($unsigned(s + 10'(BIAS)));
    for (int k = 5; k >= 0; k--) begin
      if (v >= 16'(STORE_LEN << k)) begin
        v = v - 16'(STORE_LEN << k);
      end
    end
    return v[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] cell_next(input logic [PW-1:0] p);
    return (p == LAST_CELL) ? '0 : PW'(p + 1'b1);
  endfunction

  function automatic logic [PW-1:0] cell_prev(input logic [PW-1:0] p);
    return (p == '0) ? LAST_CELL : PW'(p - 1'b1);
  endfunction

  // item latch
  logic [3:0]        func_r;
  logic signed [7:0] off_r;
  logic [7:0]        char_r;
  logic [4:0]        len_r;

  // segment store with per-cell valid bits
  logic [7:0]           store_r [STORE_LEN];
  logic [STORE_LEN-1:0] valid_r;
  logic [7:0]           rdata_r;
  logic                 rvalid_r;

  logic [PW-1:0]      win_r, win_nxt;
  logic [PW-1:0]      base_r, base_nxt;
  logic [PW-1:0]      scan_rp_r, scan_rp_nxt;
  logic [DW-1:0]      scan_digit_r, scan_digit_nxt;
  sss_pkg::mode_t     mode_r, mode_nxt;
  logic [7:0]         scount_r, scount_nxt;
  logic [PW-1:0]      cursor_r, cursor_nxt;
  logic [PW-1:0]      prev_cell_r, prev_cell_nxt;
  logic               prev_dot_r, prev_dot_nxt;
  logic [8:0]         intv_r;
  logic [PW-1:0]      addr_r, addr_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic               out_valid_r;
  logic [DW-1:0]      tick_digit_r;
  logic               tick_first_r;
  logic [1:0]         out_digit_r;
  logic [7:0]         out_seg_r;
  logic               out_first_r;
  logic               out_scroll_r;

  logic [7:0]        glyph_seg;
  logic [7:0]        rseg;
  logic [7:0]        wdata;
  logic [PW-1:0]     rp;
  logic [PW-1:0]     raddr;
  logic [7:0]        top;
  logic signed [9:0] opa, opb;
  logic [PW-1:0]     calc_pos;

  assign glyph_seg = sss_pkg::glyph(char_r);
  assign rseg      = rvalid_r ? rdata_r : 8'h00;
  assign rp        = (scan_digit_r == '0) ? win_r : scan_rp_r;
  assign raddr     = cmd.tick ? rp : addr_r;

  assign stat.func      = func_r;
  assign stat.dot_merge = (glyph_seg == sss_pkg::DOT_SEG) && !prev_dot_r;
  assign stat.cnt_zero  = (cnt_r == '0);
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_digit_index  = out_digit_r;
  assign out_segment_bits = out_seg_r;
  assign out_frame_start  = out_first_r;
  assign out_scrolling    = out_scroll_r;

  // frames per window move, clipped to 1..256
  always_comb begin
    if (intv_r == '0) begin
      top = 8'd0;
    end else if (intv_r[8] && (intv_r[7:0] != '0)) begin
      top = 8'hFF;
    end else begin
      top = 8'(intv_r - 9'd1);
    end
  end

  always_comb begin
    case (cmd.wd)
      sss_pkg::WD_GLYPH:   wdata = glyph_seg;
      sss_pkg::WD_ZERO:    wdata = 8'h00;
      sss_pkg::WD_OR_DOT:  wdata = rseg | sss_pkg::DOT_SEG;
      sss_pkg::WD_CLR_DOT: wdata = rseg & ~sss_pkg::DOT_SEG;
      default:             wdata = 8'h00;
    endcase
  end

  always_comb begin
    case (cmd.calc)
      sss_pkg::CALC_OFF:     opa = '0;
      sss_pkg::CALC_WIN_OFF: opa = $signed(10'(win_r));
      default:               opa = $signed(10'(base_r));
    endcase
    case (cmd.calc)
      sss_pkg::CALC_BASE_DIG:   opb = B_DIG;
      sss_pkg::CALC_BASE_M2:    opb = B_M2;
      sss_pkg::CALC_BASE_PDIG2: opb = B_PDIG2;
      sss_pkg::CALC_BASE_NDIG2: opb = B_NDIG2;
      default:                  opb = 10'(off_r);
    endcase
    calc_pos = cell_mod(opa + opb);
  end

  always_comb begin
    win_nxt        = win_r;
    base_nxt       = base_r;
    scan_rp_nxt    = scan_rp_r;
    scan_digit_nxt = scan_digit_r;
    mode_nxt       = mode_r;
    scount_nxt     = scount_r;
    cursor_nxt     = cursor_r;
    prev_cell_nxt  = prev_cell_r;
    prev_dot_nxt   = prev_dot_r;
    addr_nxt       = addr_r;
    cnt_nxt        = cnt_r;

    if (cmd.tick) begin
      scan_rp_nxt = cell_next(rp);
      if (scan_digit_r == LAST_DIGIT) begin
        scan_digit_nxt = '0;
        if (mode_r != sss_pkg::MODE_IDLE) begin
          if (scount_r >= top) begin
            scount_nxt = '0;
            if (win_r == base_r) begin
              mode_nxt = sss_pkg::MODE_IDLE;
            end else if (mode_r == sss_pkg::MODE_RIGHT) begin
              win_nxt = cell_next(win_r);
            end else begin
              win_nxt = cell_prev(win_r);
            end
          end else begin
            scount_nxt = scount_r + 8'd1;
          end
        end
      end else begin
        scan_digit_nxt = DW'(scan_digit_r + 1'b1);
      end
    end

    unique case (cmd.addr)
      sss_pkg::ADDR_HOLD:      addr_nxt = addr_r;
      sss_pkg::ADDR_CALC:      addr_nxt = calc_pos;
      sss_pkg::ADDR_NEXT:      addr_nxt = cell_next(addr_r);
      sss_pkg::ADDR_PREV_CELL: addr_nxt = prev_cell_r;
      sss_pkg::ADDR_CURSOR:    addr_nxt = cursor_r;
      default:                 addr_nxt = addr_r;
    endcase

    unique case (cmd.cnt)
      sss_pkg::CNT_HOLD: cnt_nxt = cnt_r;
      sss_pkg::CNT_FILL: cnt_nxt = (8'(len_r) > 8'(STORE_LEN)) ? 5'(STORE_LEN) : len_r;
      sss_pkg::CNT_TWO:  cnt_nxt = 5'd2;
      sss_pkg::CNT_DEC:  cnt_nxt = cnt_r - 5'd1;
      default:           cnt_nxt = cnt_r;
    endcase

    unique case (cmd.upd)
      sss_pkg::UPD_NONE: begin
      end
      sss_pkg::UPD_CURSOR: begin
        cursor_nxt    = addr_r;
        prev_cell_nxt = addr_r;
        prev_dot_nxt  = 1'b1;
      end
      sss_pkg::UPD_WIN: begin
        win_nxt = addr_r;
      end
      sss_pkg::UPD_BASE: begin
        base_nxt = addr_r;
      end
      sss_pkg::UPD_BASE_RIGHT: begin
        base_nxt = addr_r;
        mode_nxt = sss_pkg::MODE_RIGHT;
      end
      sss_pkg::UPD_BASE_LEFT: begin
        base_nxt = addr_r;
        mode_nxt = sss_pkg::MODE_LEFT;
      end
      sss_pkg::UPD_PRINT_PLAIN: begin
        prev_cell_nxt = cursor_r;
        cursor_nxt    = cell_next(cursor_r);
        prev_dot_nxt  = (glyph_seg == sss_pkg::DOT_SEG);
      end
      sss_pkg::UPD_PRINT_DOT: begin
        prev_cell_nxt = cursor_r;
        prev_dot_nxt  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r        <= '0;
      base_r       <= '0;
      scan_rp_r    <= '0;
      scan_digit_r <= '0;
      mode_r       <= sss_pkg::MODE_IDLE;
      scount_r     <= '0;
      cursor_r     <= '0;
      prev_cell_r  <= '0;
      prev_dot_r   <= 1'b1;
      intv_r       <= sss_pkg::INTERVAL_RESET;
      addr_r       <= '0;
      cnt_r        <= '0;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      win_r        <= win_nxt;
      base_r       <= base_nxt;
      scan_rp_r    <= scan_rp_nxt;
      scan_digit_r <= scan_digit_nxt;
      mode_r       <= mode_nxt;
      scount_r     <= scount_nxt;
      cursor_r     <= cursor_nxt;
      prev_cell_r  <= prev_cell_nxt;
      prev_dot_r   <= prev_dot_nxt;
      addr_r       <= addr_nxt;
      cnt_r        <= cnt_nxt;
      if (cfg_wr_en) begin
        intv_r <= cfg_wr_data;
      end
      if (cmd.wr) begin
        valid_r[addr_r] <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      store_r[addr_r] <= wdata;
    end
    if (cmd.rd || cmd.tick) begin
      rdata_r  <= store_r[raddr];
      rvalid_r <= valid_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r <= in_func;
      off_r  <= in_offset;
      char_r <= in_char_code;
      len_r  <= in_fill_length;
    end
    if (cmd.tick) begin
      tick_digit_r <= scan_digit_r;
      tick_first_r <= (scan_digit_r == '0);
    end
    if (cmd.emit) begin
      out_digit_r  <= 2'(tick_digit_r);
      out_seg_r    <= rseg;
      out_first_r  <= tick_first_r;
      out_scroll_r <= (mode_r != sss_pkg::MODE_IDLE);
    end
  end

endmodule

FILE: hw/rtl/seven_segment_scroll_scanner_unit.sv
`timescale 1ns / 1ps
// scan tick: the cell is read in dispatch, then emit waits for a free output register
// commands: write or apply (print, window, base), read-modify-write (dot set/clear, dot merge)
// fill: length cells up to STORE_LEN, scroll start: two blank cells, via the single store write port
// the next item is taken while a tick result waits in the output register
// synchronous active-low reset; the store reads blank at once through per-cell valid bits
module seven_segment_scroll_scanner_unit #(
  parameter int STORE_LEN = sss_pkg::STORE_LEN_DEF,
  parameter int DIGITS    = sss_pkg::DIGITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [3:0]        in_func,
  input  logic signed [7:0] in_offset,
  input  logic [7:0]        in_char_code,
  input  logic [4:0]        in_fill_length,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_digit_index,
  output logic [7:0]        out_segment_bits,
  output logic              out_frame_start,
  output logic              out_scrolling,
  input  logic              cfg_wr_en,
  input  logic [8:0]        cfg_wr_data
);

  sss_pkg::dp_cmd_t  cmd;
  sss_pkg::dp_stat_t stat;

  sss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sss_datapath #(
    .STORE_LEN (STORE_LEN),
    .DIGITS    (DIGITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_func          (in_func),
    .in_offset        (in_offset),
    .in_char_code     (in_char_code),
    .in_fill_length   (in_fill_length),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_digit_index  (out_digit_index),
    .out_segment_bits (out_segment_bits),
    .out_frame_start  (out_frame_start),
    .out_scrolling    (out_scrolling)
  );

endmodule
